FILE: rtl/lsbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbr_pkg: shared types and constants for the LSB-first bit reader
// Request and response layouts, request codes and the internal command format.
// ----------------------------------------------------------------------------
package lsbr_pkg;

  localparam int unsigned BUFFER_BITS_DEF   = 64;
  localparam int unsigned MAX_READ_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned HELD_W            = 7;
  localparam int unsigned COUNT_W           = 6;
  localparam int unsigned BYTE_W            = 8;

  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_PEEK  = 3'd2;
  localparam logic [2:0] REQ_ALIGN = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [BYTE_W-1:0]  byte_in;
    logic [COUNT_W-1:0] bit_count;
  } lsbr_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [HELD_W-1:0] bits_held;
    logic              invalid;
    logic              push_refused;
  } lsbr_rsp_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_READ,
    OP_PEEK,
    OP_ALIGN,
    OP_CLEAR,
    OP_NOP
  } lsbr_op_e;

  typedef struct packed {
    lsbr_op_e           op;
    logic [BYTE_W-1:0]  byte_val;
    logic [COUNT_W-1:0] count;
  } lsbr_cmd_t;

endpackage

FILE: rtl/lsbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbr_front: request decoder
// Maps the request code to an operation and saturates the bit count.
// ----------------------------------------------------------------------------
module lsbr_front #(
  parameter int unsigned MAX_READ_BITS = lsbr_pkg::MAX_READ_BITS_DEF
) (
  input  lsbr_pkg::lsbr_req_t req_i,
  output lsbr_pkg::lsbr_cmd_t cmd_o
);
  import lsbr_pkg::*;

  localparam logic [COUNT_W-1:0] CountMax = COUNT_W'(MAX_READ_BITS);

  always_comb begin
    cmd_o.byte_val = req_i.byte_in;
    cmd_o.count    = (req_i.bit_count > CountMax) ? CountMax : req_i.bit_count;
    unique case (req_i.req_type)
      REQ_PUSH:  cmd_o.op = OP_PUSH;
      REQ_READ:  cmd_o.op = OP_READ;
      REQ_PEEK:  cmd_o.op = OP_PEEK;
      REQ_ALIGN: cmd_o.op = OP_ALIGN;
      REQ_CLEAR: cmd_o.op = OP_CLEAR;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: rtl/lsbr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbr_fifo: small command queue
// Register-based FIFO between the decoder and the execution stage.
// ----------------------------------------------------------------------------
module lsbr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lsbr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  import lsbr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/lsbr_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbr_exec: bit buffer and execution stage
// Holds the bit buffer, executes one command per cycle unless a response stalls, registers the response.
// ----------------------------------------------------------------------------
module lsbr_exec #(
  parameter int unsigned BUFFER_BITS = lsbr_pkg::BUFFER_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  lsbr_pkg::lsbr_cmd_t cmd_i,
  output logic                cmd_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output lsbr_pkg::lsbr_rsp_t rsp_o
);
  import lsbr_pkg::*;

  localparam int unsigned HeldW = $clog2(BUFFER_BITS + 1);
  localparam logic [HeldW-1:0] PushLimit = HeldW'(BUFFER_BITS - BYTE_W);

  logic [BUFFER_BITS-1:0] buf_q, buf_d;
  logic [HeldW-1:0]       held_q, held_d, count_ext;
  logic                   bad_q, bad_d;
  logic                   rsp_valid_q;
  lsbr_rsp_t              rsp_q, rsp_d;
  logic                   pop;
  logic [DATA_W-1:0]      mask, masked;
  logic                   refused;

  assign pop         = cmd_valid_i && (!rsp_valid_q || rsp_ready_i);
  assign cmd_ready_o = pop;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign count_ext = HeldW'(cmd_i.count);
  assign mask      = (DATA_W'(1) << cmd_i.count) - DATA_W'(1);
  assign masked    = buf_q[DATA_W-1:0] & mask;

  always_comb begin
    buf_d   = buf_q;
    held_d  = held_q;
    bad_d   = bad_q;
    refused = 1'b0;
    rsp_d.data_out = '0;
    unique case (cmd_i.op)
      OP_PUSH: begin
        if (held_q > PushLimit) begin
          refused = 1'b1;
        end else begin
          buf_d  = buf_q | (BUFFER_BITS'(cmd_i.byte_val) << held_q);
          held_d = held_q + HeldW'(BYTE_W);
        end
      end
      OP_READ: begin
        if (held_q < count_ext) begin
          bad_d = 1'b1;
        end else begin
          rsp_d.data_out = masked;
          buf_d  = buf_q >> cmd_i.count;
          held_d = held_q - count_ext;
        end
      end
      OP_PEEK: begin
        rsp_d.data_out = masked;
      end
      OP_ALIGN: begin
        buf_d  = buf_q >> held_q[2:0];
        held_d = {held_q[HeldW-1:3], 3'b000};
      end
      OP_CLEAR: begin
        buf_d  = '0;
        held_d = '0;
        bad_d  = 1'b0;
      end
      default: ;
    endcase
    rsp_d.bits_held    = HELD_W'(held_d);
    rsp_d.invalid      = bad_d;
    rsp_d.push_refused = refused;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      held_q      <= '0;
      bad_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        buf_q  <= buf_d;
        held_q <= held_d;
        bad_q  <= bad_d;
      end
      if (pop) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rsp_q <= rsp_d;
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(BUFFER_BITS))
    else $error("held count above buffer size");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_q >> held_q) == '0)
    else $error("buffer bits above held count are nonzero");

  a_bad_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_q && !(pop && cmd_i.op == OP_CLEAR) |=> bad_q)
    else $error("invalid flag dropped without clear");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cmd_i.op == OP_PUSH && held_q <= PushLimit
    |=> held_q == $past(held_q) + HeldW'(BYTE_W))
    else $error("accepted push did not add a byte");
`endif

endmodule

FILE: rtl/lsb_first_bit_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_reader: LSB-first bit reader for a DEFLATE front end
// Push bytes, read/peek up to 32 bits, align to byte, clear; one response each.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the queue is not full and returns one
// response per request, in order. A request is decoded on entry into a
// two-entry queue; the execution stage takes one command a cycle from it
// unless a response waits on rsp_ready_i, updating the buffer (barrel shift,
// mask and count update) into a response register after the queue register.
// The queue lets requests keep arriving while a response waits on rsp_ready_i.
module lsb_first_bit_reader #(
  parameter int unsigned BUFFER_BITS   = lsbr_pkg::BUFFER_BITS_DEF,
  parameter int unsigned MAX_READ_BITS = lsbr_pkg::MAX_READ_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  lsbr_pkg::lsbr_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output lsbr_pkg::lsbr_rsp_t rsp_o
);
  import lsbr_pkg::*;

  localparam int unsigned CmdW = $bits(lsbr_cmd_t);

  lsbr_cmd_t cmd_in, cmd_out;
  logic      q_full, q_empty, q_pop;

  lsbr_front #(
    .MAX_READ_BITS(MAX_READ_BITS)
  ) u_front (
    .req_i(req_i),
    .cmd_o(cmd_in)
  );

  lsbr_fifo #(
    .WIDTH(CmdW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (req_valid_i),
    .wdata_i(cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(cmd_out),
    .empty_o(q_empty)
  );

  assign req_ready_o = !q_full;

  lsbr_exec #(
    .BUFFER_BITS(BUFFER_BITS)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_i      (cmd_out),
    .cmd_ready_o(q_pop),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for lsb_first_bit_reader
// Sends directed corner requests, then weighted random traffic under three
// backpressure profiles. Each response is checked field by field against an
// in-order prediction of the bit buffer.
// ----------------------------------------------------------------------------
import lsbr_pkg::*;

class bit_reader_scoreboard;
  logic [63:0] bit_buffer;
  int unsigned held_bits;
  bit          stream_bad;
  lsbr_rsp_t   pending_rsps[$];
  int unsigned mismatches;

  function new();
    clear_state();
    mismatches = 0;
  endfunction

  function void clear_state();
    bit_buffer = '0;
    held_bits  = 0;
    stream_bad = 1'b0;
  endfunction

  // Request accepted: advance the buffer and queue the response it gives.
  function void apply_request(lsbr_req_t r);
    int unsigned cnt;
    int unsigned frac;
    logic [63:0] mask;
    lsbr_rsp_t   rsp;
    rsp  = '0;
    cnt  = (r.bit_count > MAX_READ_BITS_DEF) ? MAX_READ_BITS_DEF : r.bit_count;
    mask = (cnt >= 32) ? 64'hFFFF_FFFF : ((64'd1 << cnt) - 64'd1);
    case (r.req_type)
      REQ_PUSH: begin
        if (held_bits > BUFFER_BITS_DEF - 8) begin
          rsp.push_refused = 1'b1;
        end else begin
          bit_buffer |= 64'(r.byte_in) << held_bits;
          held_bits  += 8;
        end
      end
      REQ_READ: begin
        if (held_bits < cnt) begin
          stream_bad = 1'b1;
        end else begin
          rsp.data_out = 32'(bit_buffer & mask);
          bit_buffer   = bit_buffer >> cnt;
          held_bits   -= cnt;
        end
      end
      REQ_PEEK: begin
        rsp.data_out = 32'(bit_buffer & mask);
      end
      REQ_ALIGN: begin
        frac       = held_bits % 8;
        bit_buffer = bit_buffer >> frac;
        held_bits -= frac;
      end
      REQ_CLEAR: begin
        clear_state();
      end
      default: begin
      end
    endcase
    rsp.bits_held = 7'(held_bits);
    rsp.invalid   = stream_bad;
    pending_rsps.push_back(rsp);
  endfunction

  function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_response(lsbr_rsp_t act);
    lsbr_rsp_t exp_rsp;
    if (pending_rsps.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected response, expected none actual %0h", $time, act);
    end else begin
      exp_rsp = pending_rsps.pop_front();
      check_field("data_out", exp_rsp.data_out, act.data_out);
      check_field("bits_held", exp_rsp.bits_held, act.bits_held);
      check_field("invalid", exp_rsp.invalid, act.invalid);
      check_field("push_refused", exp_rsp.push_refused, act.push_refused);
    end
  endfunction
endclass

module tb;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RAND_PER_PHASE   = 208;
  localparam logic [2:0]  REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  REQ_UNUSED_MID   = 3'd6;
  localparam logic [2:0]  REQ_CODE_LAST    = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_ready;
  lsbr_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  lsbr_rsp_t rsp;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_cnt = 0;

  bit_reader_scoreboard sb = new();

  lsb_first_bit_reader u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid && req_ready) begin
        sb.apply_request(req);
      end
      if (rsp_valid && rsp_ready) begin
        sb.check_response(rsp);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic lsbr_req_t mk_req(logic [2:0] op, logic [7:0] byte_v, logic [5:0] cnt);
    lsbr_req_t r;
    r.req_type  = op;
    r.byte_in   = byte_v;
    r.bit_count = cnt;
    return r;
  endfunction

  // Mostly pushes and short reads so the buffer keeps moving; clears are rare.
  function automatic lsbr_req_t rand_req();
    int unsigned pick;
    lsbr_req_t   r;
    pick        = $urandom_range(99);
    r.byte_in   = 8'($urandom_range(255));
    r.bit_count = ($urandom_range(3) != 0) ? 6'($urandom_range(16)) : 6'($urandom_range(63));
    if (pick < 45) begin
      r.req_type = REQ_PUSH;
    end else if (pick < 75) begin
      r.req_type = REQ_READ;
    end else if (pick < 87) begin
      r.req_type = REQ_PEEK;
    end else if (pick < 95) begin
      r.req_type = REQ_ALIGN;
    end else if (pick < 98) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_CODE_LAST));
    end
    return r;
  endfunction

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_req(lsbr_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk_i); while (!req_ready);
  endtask

  initial begin
    lsbr_req_t directed[$];
    send_idle_pct = 19;
    recv_idle_pct = 73;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(mk_req(REQ_CLEAR, 8'h00, 6'd0));
    directed.push_back(mk_req(REQ_READ, 8'h00, 6'd1));   // short read on empty
    directed.push_back(mk_req(REQ_PEEK, 8'hFF, 6'd32));
    directed.push_back(mk_req(REQ_READ, 8'h00, 6'd0));
    directed.push_back(mk_req(REQ_PUSH, 8'hFF, 6'd0));
    directed.push_back(mk_req(REQ_PUSH, 8'h00, 6'd63));
    directed.push_back(mk_req(REQ_PUSH, 8'hA5, 6'd0));
    directed.push_back(mk_req(REQ_PUSH, 8'h5A, 6'd0));
    directed.push_back(mk_req(REQ_PUSH, 8'h3C, 6'd0));
    directed.push_back(mk_req(REQ_PUSH, 8'hC3, 6'd0));
    directed.push_back(mk_req(REQ_PUSH, 8'h81, 6'd0));
    directed.push_back(mk_req(REQ_PUSH, 8'h7E, 6'd0));   // 64 bits held
    directed.push_back(mk_req(REQ_PUSH, 8'h12, 6'd0));   // refused, full
    directed.push_back(mk_req(REQ_PEEK, 8'h00, 6'd32));
    directed.push_back(mk_req(REQ_READ, 8'h00, 6'd32));
    directed.push_back(mk_req(REQ_READ, 8'h00, 6'd3));
    directed.push_back(mk_req(REQ_PUSH, 8'h96, 6'd0));   // taken at 29
    directed.push_back(mk_req(REQ_READ, 8'h00, 6'd63));  // count saturates
    directed.push_back(mk_req(REQ_ALIGN, 8'h00, 6'd0));
    directed.push_back(mk_req(REQ_PEEK, 8'h00, 6'd0));
    directed.push_back(mk_req(REQ_UNUSED_FIRST, 8'hFF, 6'd63));
    directed.push_back(mk_req(REQ_UNUSED_MID, 8'h55, 6'd21));
    directed.push_back(mk_req(REQ_CODE_LAST, 8'hAA, 6'd42));
    directed.push_back(mk_req(REQ_READ, 8'h00, 6'd33));
    directed.push_back(mk_req(REQ_CLEAR, 8'hFF, 6'd63));
    foreach (directed[i]) send_req(directed[i]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 19 : 0;
      repeat (RAND_PER_PHASE) send_req(rand_req());
    end
    req_valid <= 1'b0;
    @(posedge clk_i);

    while (sb.pending_rsps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_rsps.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
